### sv/stpe_pkg.sv
// ----------------------------------------------------------------------------
// stpe_pkg
// Shared types, operation codes and saturation helper for the tableau engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stpe_pkg;

  localparam logic [2:0] OP_WRITE   = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_ENTER   = 3'd2;
  localparam logic [2:0] OP_RATIO   = 3'd3;
  localparam logic [2:0] OP_DIV_ROW = 3'd4;
  localparam logic [2:0] OP_ELIM    = 3'd5;
  localparam logic [2:0] OP_DIV_RHS = 3'd6;

  localparam logic [1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [1:0] CFG_COL_COUNT = 2'd1;

  localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic [2:0]         op;
    logic [3:0]         row;
    logic [4:0]         column;
    logic signed [31:0] value;
    logic [4:0]         row_count;
    logic [5:0]         col_count;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [4:0]         index;
    logic               none_found;
    logic               divide_error;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = Q_MAX;
    end else if (v < SAT_LO) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/stpe_ram.sv
// ----------------------------------------------------------------------------
// stpe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/stpe_div.sv
// ----------------------------------------------------------------------------
// stpe_div
// Radix-2 restoring fixed-point divider: (a << FRAC_BITS) / b, truncated toward
// zero and saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stpe_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic                    done,
  output logic signed [31:0]      q
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int KW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          fin_r, fin_nxt;
  logic          done_r, done_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   bmag_r, bmag_nxt;
  logic          neg_r, neg_nxt;
  logic signed [31:0] q_r, q_nxt;

  always_comb begin
    logic [31:0] amag;
    logic [32:0] rem_sh;
    logic signed [63:0] wide;
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    bmag_nxt = bmag_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    amag     = a[31] ? (32'd0 - a) : a;
    rem_sh   = {rem_r, num_r[NW-1]};
    wide     = neg_r ? (64'sd0 - $signed(64'(quo_r))) : $signed(64'(quo_r));
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = KW'(NW);
      num_nxt  = {amag, {FRAC_BITS{1'b0}}};
      quo_nxt  = '0;
      rem_nxt  = '0;
      bmag_nxt = b[31] ? (32'd0 - b) : b;
      neg_nxt  = a[31] ^ b[31];
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], 1'b0};
      if (rem_sh >= {1'b0, bmag_r}) begin
        rem_nxt = 32'(rem_sh - {1'b0, bmag_r});
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[31:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - KW'(1);
      if (cnt_r == KW'(1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      q_nxt    = stpe_pkg::sat32(wide);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    bmag_r <= bmag_nxt;
    neg_r  <= neg_nxt;
    q_r    <= q_nxt;
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

`default_nettype wire

### sv/stpe_seq.sv
// ----------------------------------------------------------------------------
// stpe_seq
// Operation sequencer: walks the tableau memory element by element, runs the
// shared divider and the multiply-accumulate path, and builds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stpe_seq #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire stpe_pkg::cmd_t  cmd,
  output logic                 idle,
  output logic                 res_valid,
  input  wire logic            res_take,
  output stpe_pkg::res_t       res
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int RNW = RW + 1;
  localparam int CNW = CW + 1;
  localparam int AW  = RW + CW;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_CHK    = 5'd1;
  localparam logic [4:0] ST_RD     = 5'd2;
  localparam logic [4:0] ST_EN_RD  = 5'd3;
  localparam logic [4:0] ST_EN_CMP = 5'd4;
  localparam logic [4:0] ST_RT_E   = 5'd5;
  localparam logic [4:0] ST_RT_H   = 5'd6;
  localparam logic [4:0] ST_RT_D   = 5'd7;
  localparam logic [4:0] ST_RT_W   = 5'd8;
  localparam logic [4:0] ST_DR_RD  = 5'd9;
  localparam logic [4:0] ST_DR_DIV = 5'd10;
  localparam logic [4:0] ST_DR_W   = 5'd11;
  localparam logic [4:0] ST_EL_PIV = 5'd12;
  localparam logic [4:0] ST_EL_F   = 5'd13;
  localparam logic [4:0] ST_EL_FD  = 5'd14;
  localparam logic [4:0] ST_EL_FW  = 5'd15;
  localparam logic [4:0] ST_EL_RA  = 5'd16;
  localparam logic [4:0] ST_EL_RB  = 5'd17;
  localparam logic [4:0] ST_EL_MUL = 5'd18;
  localparam logic [4:0] ST_EL_TR  = 5'd19;
  localparam logic [4:0] ST_EL_WR  = 5'd20;
  localparam logic [4:0] ST_RH_E   = 5'd21;
  localparam logic [4:0] ST_RH_H   = 5'd22;
  localparam logic [4:0] ST_RH_D   = 5'd23;
  localparam logic [4:0] ST_RH_W   = 5'd24;
  localparam logic [4:0] ST_DONE   = 5'd25;

  logic [4:0]           state_r, state_nxt;
  stpe_pkg::cmd_t       cmd_r, cmd_nxt;
  stpe_pkg::res_t       res_r, res_nxt;
  logic [RNW-1:0]       rows_r, rows_nxt;
  logic [CNW-1:0]       cols_r, cols_nxt;
  logic [RNW-1:0]       i_r, i_nxt;
  logic [CNW-1:0]       j_r, j_nxt;
  logic signed [31:0]   a_r, a_nxt;
  logic signed [31:0]   b_r, b_nxt;
  logic signed [31:0]   best_r, best_nxt;
  logic [4:0]           idx_r, idx_nxt;
  logic                 found_r, found_nxt;
  logic signed [31:0]   piv_r, piv_nxt;
  logic signed [31:0]   s_r, s_nxt;
  logic signed [31:0]   t_r, t_nxt;
  logic signed [63:0]   prod_r, prod_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [31:0]          ram_wdata, ram_rdata;
  logic signed [31:0]   rd;

  logic                 div_start, div_done;
  logic signed [31:0]   div_a, div_b, div_q;

  stpe_ram #(
    .WIDTH (32),
    .DEPTH (2 ** AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stpe_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .q     (div_q)
  );

  assign rd = $signed(ram_rdata);

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] ri,
                                            input logic [CW-1:0] ci);
    return {ri, ci};
  endfunction

  // Accesses are strictly ordered by the sequencer: a write is never followed
  // by a read of the same entry in the next cycle, so no forwarding is needed.
  always_comb begin
    logic [8:0]         rc9, cc9;
    logic [RNW-1:0]     last_row;
    logic [CNW-1:0]     last_col;
    logic [CW-1:0]      cidx;
    logic [RW-1:0]      ridx;
    logic               row_in, col_in;
    logic signed [63:0] shv;
    logic signed [31:0] sv;
    logic               upd;
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    res_nxt   = res_r;
    rows_nxt  = rows_r;
    cols_nxt  = cols_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    best_nxt  = best_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    piv_nxt   = piv_r;
    s_nxt     = s_r;
    t_nxt     = t_r;
    prod_nxt  = prod_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    div_start = 1'b0;
    div_a     = a_r;
    div_b     = b_r;
    last_row  = rows_r - RNW'(1);
    last_col  = cols_r - CNW'(1);
    cidx      = CW'(cmd_r.column);
    ridx      = RW'(cmd_r.row);
    row_in    = 9'(cmd_r.row) < 9'(rows_r);
    col_in    = 9'(cmd_r.column) < 9'(cols_r);
    rc9       = 9'(cmd.row_count);
    cc9       = 9'(cmd.col_count);
    shv       = prod_r >>> FRAC_BITS;
    sv        = '0;
    upd       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd;
          res_nxt   = '0;
          i_nxt     = '0;
          j_nxt     = '0;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          rows_nxt  = (rc9 < 9'd2) ? RNW'(2) :
                      (rc9 > 9'(MAX_ROWS)) ? RNW'(MAX_ROWS) : RNW'(rc9);
          cols_nxt  = (cc9 < 9'd2) ? CNW'(2) :
                      (cc9 > 9'(MAX_COLS)) ? CNW'(MAX_COLS) : CNW'(cc9);
          unique case (cmd.op)
            stpe_pkg::OP_WRITE: begin
              ram_we    = (9'(cmd.row) < 9'(MAX_ROWS)) &&
                          (9'(cmd.column) < 9'(MAX_COLS));
              ram_waddr = addr_of(RW'(cmd.row), CW'(cmd.column));
              ram_wdata = cmd.value;
              state_nxt = ST_DONE;
            end
            stpe_pkg::OP_READ: begin
              ram_raddr = addr_of(RW'(cmd.row), CW'(cmd.column));
              state_nxt = ST_RD;
            end
            stpe_pkg::OP_ENTER, stpe_pkg::OP_RATIO, stpe_pkg::OP_DIV_ROW,
            stpe_pkg::OP_ELIM, stpe_pkg::OP_DIV_RHS: begin
              state_nxt = ST_CHK;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_CHK: begin
        unique case (cmd_r.op)
          stpe_pkg::OP_ENTER: state_nxt = ST_EN_RD;
          stpe_pkg::OP_RATIO: begin
            if (!col_in) begin
              res_nxt.none_found = 1'b1;
              state_nxt          = ST_DONE;
            end else begin
              state_nxt = ST_RT_E;
            end
          end
          stpe_pkg::OP_DIV_ROW: begin
            if (cmd_r.value == 32'sd0) begin
              res_nxt.divide_error = 1'b1;
              state_nxt            = ST_DONE;
            end else if (!row_in) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_DR_RD;
            end
          end
          stpe_pkg::OP_ELIM: begin
            if (!row_in || !col_in) begin
              state_nxt = ST_DONE;
            end else begin
              ram_raddr = addr_of(ridx, cidx);
              state_nxt = ST_EL_PIV;
            end
          end
          stpe_pkg::OP_DIV_RHS: begin
            state_nxt = col_in ? ST_RH_E : ST_DONE;
          end
          default: state_nxt = ST_DONE;
        endcase
      end

      ST_RD: begin
        if ((9'(cmd_r.row) < 9'(MAX_ROWS)) && (9'(cmd_r.column) < 9'(MAX_COLS))) begin
          res_nxt.data = rd;
        end
        state_nxt = ST_DONE;
      end

      // entering column: scan the objective row
      ST_EN_RD: begin
        ram_raddr = addr_of(last_row[RW-1:0], j_r[CW-1:0]);
        state_nxt = ST_EN_CMP;
      end
      ST_EN_CMP: begin
        if ((j_r == '0) || (rd < best_r)) begin
          best_nxt = rd;
          idx_nxt  = 5'(j_r);
        end
        if (j_r == cols_r - CNW'(2)) begin
          res_nxt.index = idx_nxt;
          state_nxt     = ST_DONE;
        end else begin
          j_nxt     = j_r + CNW'(1);
          state_nxt = ST_EN_RD;
        end
      end

      // ratio test
      ST_RT_E: begin
        ram_raddr = addr_of(i_r[RW-1:0], cidx);
        state_nxt = ST_RT_H;
      end
      ST_RT_H: begin
        b_nxt     = rd;
        ram_raddr = addr_of(i_r[RW-1:0], last_col[CW-1:0]);
        state_nxt = ST_RT_D;
      end
      ST_RT_D, ST_RT_W: begin
        if (state_r == ST_RT_D && b_r != 32'sd0) begin
          div_start = 1'b1;
          div_a     = rd;
          state_nxt = ST_RT_W;
        end else if (state_r == ST_RT_D || div_done) begin
          if (state_r == ST_RT_W && div_q > 32'sd0 && (!found_r || div_q < best_r)) begin
            best_nxt  = div_q;
            idx_nxt   = 5'(i_r);
            found_nxt = 1'b1;
          end
          if (i_r == rows_r - RNW'(2)) begin
            res_nxt.index      = found_nxt ? idx_nxt : 5'd0;
            res_nxt.none_found = !found_nxt;
            state_nxt          = ST_DONE;
          end else begin
            i_nxt     = i_r + RNW'(1);
            state_nxt = ST_RT_E;
          end
        end
      end

      // divide row
      ST_DR_RD: begin
        ram_raddr = addr_of(ridx, j_r[CW-1:0]);
        state_nxt = ST_DR_DIV;
      end
      ST_DR_DIV: begin
        div_start = 1'b1;
        div_a     = rd;
        div_b     = cmd_r.value;
        state_nxt = ST_DR_W;
      end
      ST_DR_W: begin
        if (div_done) begin
          ram_we    = 1'b1;
          ram_waddr = addr_of(ridx, j_r[CW-1:0]);
          ram_wdata = div_q;
          if (j_r == last_col) begin
            state_nxt = ST_DONE;
          end else begin
            j_nxt     = j_r + CNW'(1);
            state_nxt = ST_DR_RD;
          end
        end
      end

      // eliminate
      ST_EL_PIV: begin
        piv_nxt = rd;
        if (rd == 32'sd0) begin
          res_nxt.divide_error = 1'b1;
          state_nxt            = ST_DONE;
        end else begin
          state_nxt = ST_EL_F;
        end
      end
      ST_EL_F: begin
        if (9'(i_r) == 9'(cmd_r.row)) begin
          upd = 1'b1;
        end else begin
          ram_raddr = addr_of(i_r[RW-1:0], cidx);
          state_nxt = ST_EL_FD;
        end
      end
      ST_EL_FD: begin
        div_start = 1'b1;
        div_a     = rd;
        div_b     = piv_r;
        state_nxt = ST_EL_FW;
      end
      ST_EL_FW: begin
        if (div_done) begin
          sv = (div_q == stpe_pkg::Q_MIN) ? stpe_pkg::Q_MAX : -div_q;
          if (sv == 32'sd0) begin
            upd = 1'b1;
          end else begin
            s_nxt     = sv;
            j_nxt     = '0;
            state_nxt = ST_EL_RA;
          end
        end
      end
      ST_EL_RA: begin
        ram_raddr = addr_of(ridx, j_r[CW-1:0]);
        state_nxt = ST_EL_RB;
      end
      ST_EL_RB: begin
        a_nxt     = rd;
        ram_raddr = addr_of(i_r[RW-1:0], j_r[CW-1:0]);
        state_nxt = ST_EL_MUL;
      end
      ST_EL_MUL: begin
        t_nxt     = rd;
        prod_nxt  = a_r * s_r;
        state_nxt = ST_EL_TR;
      end
      ST_EL_TR: begin
        // truncate toward zero
        if (prod_r[63] && (prod_r[FRAC_BITS-1:0] != '0)) begin
          prod_nxt = shv + 64'sd1;
        end else begin
          prod_nxt = shv;
        end
        state_nxt = ST_EL_WR;
      end
      ST_EL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(i_r[RW-1:0], j_r[CW-1:0]);
        ram_wdata = stpe_pkg::sat32(64'(t_r) + prod_r);
        if (j_r == last_col) begin
          upd = 1'b1;
        end else begin
          j_nxt     = j_r + CNW'(1);
          state_nxt = ST_EL_RA;
        end
      end

      // divide right-hand side
      ST_RH_E: begin
        ram_raddr = addr_of(i_r[RW-1:0], cidx);
        state_nxt = ST_RH_H;
      end
      ST_RH_H: begin
        b_nxt     = rd;
        ram_raddr = addr_of(i_r[RW-1:0], last_col[CW-1:0]);
        state_nxt = ST_RH_D;
      end
      ST_RH_D: begin
        if (b_r != 32'sd0) begin
          div_start = 1'b1;
          div_a     = rd;
          state_nxt = ST_RH_W;
        end else begin
          upd = 1'b1;
        end
      end
      ST_RH_W: begin
        if (div_done) begin
          ram_we    = 1'b1;
          ram_waddr = addr_of(i_r[RW-1:0], last_col[CW-1:0]);
          ram_wdata = div_q;
          upd       = 1'b1;
        end
      end

      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // advance to the next row of an elimination or rhs pass
    if (upd) begin
      if (i_r == last_row) begin
        state_nxt = ST_DONE;
      end else begin
        i_nxt     = i_r + RNW'(1);
        state_nxt = (cmd_r.op == stpe_pkg::OP_ELIM) ? ST_EL_F : ST_RH_E;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r   <= cmd_nxt;
    res_r   <= res_nxt;
    rows_r  <= rows_nxt;
    cols_r  <= cols_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    best_r  <= best_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    piv_r   <= piv_nxt;
    s_r     <= s_nxt;
    t_r     <= t_nxt;
    prod_r  <= prod_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

endmodule

`default_nettype wire

### sv/simplex_tableau_pivot_engine.sv
// ----------------------------------------------------------------------------
// simplex_tableau_pivot_engine
// Simplex tableau in one RAM with element, pivot-search and pivot operations.
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | in_tdata: op, row, column, value
//  out_    | out | out_tvalid/out_tready | out_tdata: data, index, flags
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One item at a time. The run time of the search, division and elimination
// operations is set by the single RAM read port and the bit-serial divider.
// rst_n is synchronous; the tableau is not cleared. A result held by a stalled
// out_tready does not block the next input transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module simplex_tableau_pivot_engine #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] operation, [6:3] row, [11:7] column, [43:12] value, [47:44] zero
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] data, [36:32] index, [37] none_found, [38] divide_error, [39] zero
  output logic [39:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);

  logic [4:0]     row_count_r, row_count_nxt;
  logic [5:0]     col_count_r, col_count_nxt;
  logic           out_valid_r, out_valid_nxt;
  stpe_pkg::res_t out_res_r, out_res_nxt;
  stpe_pkg::cmd_t cmd;
  stpe_pkg::res_t res;
  logic           seq_idle, res_valid, res_take, start;

  assign cfg_ready = 1'b1;
  assign in_tready = seq_idle;
  assign start     = in_tvalid && in_tready;
  assign res_take  = res_valid && (!out_valid_r || out_tready);

  always_comb begin
    cmd.op        = in_tdata[2:0];
    cmd.row       = in_tdata[6:3];
    cmd.column    = in_tdata[11:7];
    cmd.value     = $signed(in_tdata[43:12]);
    cmd.row_count = row_count_r;
    cmd.col_count = col_count_r;
  end

  stpe_seq #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (cmd),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stpe_pkg::CFG_ROW_COUNT: row_count_nxt = cfg_data[4:0];
        stpe_pkg::CFG_COL_COUNT: col_count_nxt = cfg_data;
        default: ;
      endcase
    end
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_res_nxt   = res;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= 5'd2;
      col_count_r <= 6'd2;
      out_valid_r <= 1'b0;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.divide_error, out_res_r.none_found,
                       out_res_r.index, out_res_r.data};

`ifndef SYNTH
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sequencer ready right after a transfer");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(res_valid))
    else $error("result shown without sequencer completion");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[37] && out_tdata[38]))
    else $error("none_found and divide_error both set");

  a_none_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[37] |-> out_tdata[36:32] == 5'd0)
    else $error("index not zero with none_found");
`endif

endmodule

`default_nettype wire
